@@ rtl/core/srpg_pkg.sv @@
// Shared types and constants for the servo ramp profile generator.
// No dependencies; imported by the multiply/divide unit and the top level.
package srpg_pkg;

  localparam int PosW  = 12;
  localparam int SpdW  = 8;
  localparam int StepW = 9;
  localparam int QuarW = 10;
  localparam int ProdW = 18;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_MOVE   = 2'd1;
  localparam logic [1:0] OP_ATTACH = 2'd2;
  localparam logic [1:0] OP_DETACH = 2'd3;

  localparam logic [SpdW-1:0] MIN_STEP_RESET = 8'd20;

  // Request into the shared multiply/divide unit: full * mult / divisor.
  typedef struct packed {
    logic             start;
    logic [SpdW-1:0]  full;
    logic [QuarW-1:0] mult;
    logic [QuarW-1:0] divisor;
  } mdu_req_t;

  // Completion status of the unit; quotient is valid while done is high.
  typedef struct packed {
    logic            done;
    logic [SpdW-1:0] quotient;
  } mdu_stat_t;

endpackage

@@ rtl/core/srpg_mdu.sv @@
// Serial multiply-then-divide unit built around one shared add/subtract stage.
// Depends on srpg_pkg for the request and status structs.
module srpg_mdu (
  input  logic              clk,
  input  logic              rst,
  input  srpg_pkg::mdu_req_t  req,
  output srpg_pkg::mdu_stat_t stat
);
  import srpg_pkg::*;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;
  localparam logic [1:0] M_DONE = 2'd3;

  logic [1:0]       mstate;
  logic [2:0]       cnt;
  logic [SpdW-1:0]  mcand;
  logic [QuarW-1:0] mplier;
  logic [ProdW-1:0] acc;
  logic [ProdW-2:0] dsh;
  logic [SpdW-1:0]  quo;

  logic [ProdW-1:0] opa;
  logic [ProdW-1:0] opb;
  logic             sub;
  logic [ProdW:0]   sum;

  // The one adder: shift-add while multiplying, trial subtract while dividing.
  always_comb begin
    if (mstate == M_DIV) begin
      opa = acc;
      opb = {1'b0, dsh};
      sub = 1'b1;
    end else begin
      opa = {acc[ProdW-2:0], 1'b0};
      opb = mcand[SpdW-1] ? {{(ProdW-QuarW){1'b0}}, mplier} : '0;
      sub = 1'b0;
    end
    sum = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + {{ProdW{1'b0}}, sub};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= M_IDLE;
      cnt    <= '0;
    end else begin
      unique case (mstate)
        M_IDLE: begin
          if (req.start) begin
            mcand  <= req.full;
            mplier <= req.mult;
            dsh    <= {req.divisor, 7'd0};
            acc    <= '0;
            cnt    <= '0;
            mstate <= M_MUL;
          end
        end
        M_MUL: begin
          acc   <= sum[ProdW-1:0];
          mcand <= {mcand[SpdW-2:0], 1'b0};
          cnt   <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            mstate <= M_DIV;
          end
        end
        M_DIV: begin
          // Carry out set means no borrow: the shifted divisor fits.
          if (sum[ProdW]) begin
            acc <= sum[ProdW-1:0];
          end
          quo <= {quo[SpdW-2:0], sum[ProdW]};
          dsh <= {1'b0, dsh[ProdW-2:1]};
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            mstate <= M_DONE;
          end
        end
        M_DONE: begin
          mstate <= M_IDLE;
        end
        default: begin
          mstate <= M_IDLE;
        end
      endcase
    end
  end

  assign stat.done     = (mstate == M_DONE);
  assign stat.quotient = quo;

endmodule

@@ rtl/core/servo_ramp_profile_generator.sv @@
// Top level of the servo ramp profile generator: sequencer and channel state.
// Depends on srpg_pkg and instantiates srpg_mdu.
//
// Each accepted item (tick, move, attach or detach on one channel) produces
// exactly one result item describing that channel afterward. Items are handled
// one at a time. A move, attach or detach, or a tick on an idle or detached
// channel, goes from capture through evaluation straight to the apply step,
// which loads the result register. A tick in the middle of the travel adds a
// phase decision step before apply. A tick that falls in the first or last
// quarter of the travel scales the step with one serial multiply followed by
// one serial restoring divide on a shared adder, and the sequencer waits for
// the unit to finish before apply. The result register lets the next item be
// accepted while a finished result still waits to be taken; that next item
// then waits in its last step until the result is taken. The min_step register
// is written through its own channel, which is ready whenever the block is out
// of reset.
module servo_ramp_profile_generator #(
  parameter int CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  min_step,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic        channel,
  input  logic [7:0]  speed,
  input  logic [11:0] target,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_channel,
  output logic [11:0] position,
  output logic        position_changed,
  output logic        arrived,
  output logic        is_attached,
  output logic        is_moving
);
  import srpg_pkg::*;

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_PHASE = 3'd2;
  localparam logic [2:0] S_MDU   = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;

  // Per-channel state.
  logic [PosW-1:0]         cur_arr   [CHANNELS];
  logic [PosW-1:0]         goal_arr  [CHANNELS];
  logic signed [StepW-1:0] step_arr  [CHANNELS];
  logic [PosW-1:0]         start_arr [CHANNELS];
  logic                    att_arr   [CHANNELS];
  logic                    mov_arr   [CHANNELS];

  logic [SpdW-1:0] step_floor;
  logic [2:0]      state;

  // Working copy of the item and of its channel's state.
  logic [1:0]              op;
  logic                    ch;
  logic [IdxW-1:0]         idx;
  logic                    ok;
  logic [SpdW-1:0]         spd;
  logic [PosW-1:0]         tgt;
  logic [PosW-1:0]         cur;
  logic [PosW-1:0]         goal;
  logic signed [StepW-1:0] step;
  logic [PosW-1:0]         start;
  logic                    att;
  logic                    mov;
  logic [PosW-1:0]         gap;
  logic                    up;
  logic                    act;
  logic [PosW-1:0]         tdist;
  logic                    tdown;
  logic                    tsame;
  logic [SpdW-1:0]         mag;

  logic [IdxW-1:0] idx_in;
  logic            ok_in;
  logic            in_fire;
  logic            apply_fire;

  mdu_req_t  req;
  mdu_stat_t stat;

  logic [QuarW-1:0] quar;
  logic [SpdW-1:0]  full;
  logic [StepW-1:0] step_neg;
  logic [PosW:0]    dist_q_sum;
  logic [PosW-1:0]  covered;

  logic [SpdW-1:0]         ms;
  logic [SpdW-1:0]         magc;
  logic                    reach;
  logic [PosW-1:0]         np;
  logic [PosW-1:0]         n_cur;
  logic [PosW-1:0]         n_goal;
  logic signed [StepW-1:0] n_step;
  logic [PosW-1:0]         n_start;
  logic                    n_att;
  logic                    n_mov;
  logic                    n_arr;
  logic                    n_chg;

  logic [IdxW-1:0] out_idx;

  assign cfg_ready  = !rst;
  assign in_ready   = (state == S_IDLE) && !rst;
  assign in_fire    = in_valid && in_ready;
  assign apply_fire = (state == S_APPLY) && (!out_valid || out_ready);
  assign idx_in     = IdxW'(channel);
  assign ok_in      = (int'(channel) < CHANNELS);
  assign out_idx    = IdxW'(out_channel);

  // Phase decision: quarter of the travel, full step magnitude and the
  // distance already covered, all from the captured channel state.
  always_comb begin
    quar       = start[PosW-1:2];
    step_neg   = -step;
    full       = step[StepW-1] ? step_neg[SpdW-1:0] : step[SpdW-1:0];
    dist_q_sum = {1'b0, gap} + {3'd0, quar};
    covered    = (start > gap) ? (start - gap) : '0;

    req.start   = 1'b0;
    req.full    = full;
    req.divisor = quar;
    req.mult    = gap[QuarW-1:0];
    if (state == S_PHASE && quar != '0) begin
      if (gap < {2'd0, quar}) begin
        req.start = 1'b1;
      end else if (dist_q_sum > {1'b0, start}) begin
        req.start = 1'b1;
        req.mult  = covered[QuarW-1:0];
      end
    end
  end

  srpg_mdu u_mdu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .stat (stat)
  );

  // Next channel state and result flags for the item being finished.
  always_comb begin
    ms    = (step_floor == '0) ? 8'd1 : step_floor;
    magc  = (mag < ms) ? ms : mag;
    reach = ({4'd0, magc} >= gap);
    if (reach) begin
      np = goal;
    end else if (up) begin
      np = cur + {4'd0, magc};
    end else begin
      np = cur - {4'd0, magc};
    end

    n_cur   = cur;
    n_goal  = goal;
    n_step  = step;
    n_start = start;
    n_att   = att;
    n_mov   = mov;
    n_arr   = 1'b0;
    n_chg   = 1'b0;
    unique case (op)
      OP_TICK: begin
        if (act) begin
          n_cur = np;
          n_chg = 1'b1;
          if (reach) begin
            n_arr = 1'b1;
            n_mov = 1'b0;
          end
        end
      end
      OP_MOVE: begin
        n_goal = tgt;
        n_att  = 1'b1;
        if (tsame) begin
          n_arr = 1'b1;
          n_mov = 1'b0;
        end else begin
          n_step  = tdown ? -$signed({1'b0, spd}) : $signed({1'b0, spd});
          n_start = tdist;
          n_mov   = 1'b1;
        end
      end
      OP_ATTACH: begin
        n_att = 1'b1;
      end
      OP_DETACH: begin
        n_att = 1'b0;
        n_mov = 1'b0;
      end
      default: begin
        n_att = att;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      step_floor <= MIN_STEP_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        cur_arr[i]   <= '0;
        goal_arr[i]  <= '0;
        step_arr[i]  <= '0;
        start_arr[i] <= '0;
        att_arr[i]   <= 1'b0;
        mov_arr[i]   <= 1'b0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_floor <= min_step;
      end
      // A result taken at the same edge that a new one is loaded stays valid.
      if (out_valid && out_ready && !apply_fire) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            op    <= opcode;
            ch    <= channel;
            idx   <= idx_in;
            ok    <= ok_in;
            spd   <= speed;
            tgt   <= target;
            cur   <= cur_arr[idx_in];
            goal  <= goal_arr[idx_in];
            step  <= step_arr[idx_in];
            start <= start_arr[idx_in];
            att   <= att_arr[idx_in];
            mov   <= mov_arr[idx_in];
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          gap   <= (cur > goal) ? (cur - goal) : (goal - cur);
          up    <= (goal > cur);
          act   <= att && (cur != goal);
          tdist <= (tgt > cur) ? (tgt - cur) : (cur - tgt);
          tdown <= (tgt < cur);
          tsame <= (tgt == cur);
          if (op == OP_TICK && att && cur != goal) begin
            state <= S_PHASE;
          end else begin
            state <= S_APPLY;
          end
        end
        S_PHASE: begin
          if (req.start) begin
            state <= S_MDU;
          end else begin
            mag   <= full;
            state <= S_APPLY;
          end
        end
        S_MDU: begin
          if (stat.done) begin
            mag   <= stat.quotient;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply_fire) begin
            out_valid   <= 1'b1;
            out_channel <= ch;
            if (ok) begin
              cur_arr[idx]     <= n_cur;
              goal_arr[idx]    <= n_goal;
              step_arr[idx]    <= n_step;
              start_arr[idx]   <= n_start;
              att_arr[idx]     <= n_att;
              mov_arr[idx]     <= n_mov;
              position         <= n_cur;
              position_changed <= n_chg;
              arrived          <= n_arr;
              is_attached      <= n_att;
              is_moving        <= n_mov;
            end else begin
              position         <= '0;
              position_changed <= 1'b0;
              arrived          <= 1'b0;
              is_attached      <= 1'b0;
              is_moving        <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The divide unit only finishes while the sequencer is waiting for it.
  a_done_in_mdu: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (state == S_MDU))
    else $error("divide unit finished outside its wait state");

  // A scaled step never exceeds the full step of the move.
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (stat.quotient <= full))
    else $error("scaled step larger than full step");

  // A reported arrival leaves the channel sitting exactly on its goal.
  a_arrive_on_goal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && arrived) |-> (position == goal_arr[out_idx]))
    else $error("arrival reported away from the goal");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the two-channel servo ramp profile generator.
// Depends on srpg_pkg and servo_ramp_profile_generator; a built-in ramp
// predictor checks every result item in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srpg_pkg::*;

  // Cycles with no handshake at all before the run is declared hung. This
  // leaves a wide margin over the slowest item and over the random stalls at
  // 79 percent.
  localparam int WatchdogLimit = 2000;
  // Quiet time after the last result before min_step is rewritten or the run
  // ends; a little more than the slowest item.
  localparam int SettleCycles = 30;

  // One command item as it goes onto the input channel.
  typedef struct packed {
    logic [1:0]      op;
    logic            chan;
    logic [SpdW-1:0] speed;
    logic [PosW-1:0] target;
  } servo_cmd_t;

  // Per-channel motion state. Only the magnitude of the full step is kept,
  // since the direction of every tick follows goal versus position.
  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [PosW-1:0] goal;
    logic [SpdW-1:0] full;
    logic [PosW-1:0] span;
    logic            att;
    logic            mov;
  } servo_chan_t;

  // One result item.
  typedef struct packed {
    logic            chan;
    logic [PosW-1:0] pos;
    logic            changed;
    logic            arrived;
    logic            att;
    logic            mov;
  } servo_report_t;

  typedef struct packed {
    servo_chan_t   state;
    servo_report_t res;
  } servo_update_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [7:0]      min_step = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [1:0]      opcode = OP_TICK;
  logic            channel = 1'b0;
  logic [7:0]      speed = '0;
  logic [11:0]     target = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic            out_channel;
  logic [11:0]     position;
  logic            position_changed;
  logic            arrived;
  logic            is_attached;
  logic            is_moving;

  // Commands waiting for the driver, and the results predicted for the
  // commands that the block has already taken.
  servo_cmd_t      pending_cmds[$];
  servo_report_t   expected_reports[$];

  // Predictor state, advanced at each accepted item or register write.
  servo_chan_t     servo_state[2];
  logic [7:0]      step_floor;
  // Planning copy used while building a phase, so that move sequences can
  // be ticked through to arrival.
  servo_chan_t     plan_state[2];
  logic [7:0]      plan_floor;

  int              send_idle_pct = 9;
  int              recv_idle_pct = 79;
  int              items_queued = 0;
  int              items_sent = 0;
  int              items_accepted = 0;
  int              useful_items = 0;
  int              mismatches = 0;
  int              idle_cycles = 0;
  logic            send_next;
  servo_cmd_t      next_cmd;

  servo_ramp_profile_generator #(
    .CHANNELS(2)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .min_step(min_step),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .channel(channel),
    .speed(speed),
    .target(target),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_channel(out_channel),
    .position(position),
    .position_changed(position_changed),
    .arrived(arrived),
    .is_attached(is_attached),
    .is_moving(is_moving)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Applies one command to one channel. A tick on an attached channel that
  // is away from its goal moves by one step: the full step in the middle of
  // the travel, scaled by the distance covered in the first quarter and by
  // the distance left in the last quarter. The step is never below the
  // floor (zero counts as one) and never overshoots the goal.
  function automatic servo_update_t ramp_step(servo_chan_t st, servo_cmd_t cmd,
                                              logic [7:0] floor_q);
    servo_update_t u;
    int cur;
    int goal;
    int gap;
    int span;
    int quarter;
    int mag;
    int least;
    int np;
    u = '0;
    u.state = st;
    u.res.chan = cmd.chan;
    cur = st.pos;
    goal = st.goal;
    case (cmd.op)
      OP_TICK: begin
        if (st.att && cur != goal) begin
          gap = (cur > goal) ? cur - goal : goal - cur;
          span = st.span;
          quarter = span >> 2;
          if (quarter == 0) begin
            mag = st.full;
          end else if (gap < quarter) begin
            mag = st.full * gap / quarter;
          end else if (gap + quarter > span) begin
            mag = st.full * ((span > gap) ? span - gap : 0) / quarter;
          end else begin
            mag = st.full;
          end
          least = (floor_q == 0) ? 1 : floor_q;
          if (mag < least) mag = least;
          if (goal > cur) begin
            np = (mag >= goal - cur) ? goal : cur + mag;
          end else begin
            np = (mag >= cur - goal) ? goal : cur - mag;
          end
          u.state.pos = np[PosW-1:0];
          u.res.changed = (np != cur);
          if (np == goal) begin
            u.res.arrived = 1'b1;
            u.state.mov = 1'b0;
          end
        end
      end
      OP_MOVE: begin
        u.state.goal = cmd.target;
        if (cmd.target == st.pos) begin
          // Already there: step and travel length are left as they were.
          u.state.mov = 1'b0;
          u.res.arrived = 1'b1;
        end else begin
          u.state.full = cmd.speed;
          u.state.span = (cmd.target > st.pos) ? cmd.target - st.pos
                                               : st.pos - cmd.target;
          u.state.mov = 1'b1;
        end
        u.state.att = 1'b1;
      end
      OP_ATTACH: begin
        u.state.att = 1'b1;
      end
      OP_DETACH: begin
        u.state.att = 1'b0;
        u.state.mov = 1'b0;
      end
    endcase
    u.res.pos = u.state.pos;
    u.res.att = u.state.att;
    u.res.mov = u.state.mov;
    return u;
  endfunction

  // Queues one command and runs it through the planning copy. Ticks that
  // change nothing are not counted toward the size of a phase.
  task automatic queue_cmd(input logic [1:0] op, input logic ch,
                           input logic [7:0] spd, input logic [11:0] tgt);
    servo_cmd_t    cmd;
    servo_update_t u;
    cmd.op = op;
    cmd.chan = ch;
    cmd.speed = spd;
    cmd.target = tgt;
    u = ramp_step(plan_state[ch], cmd, plan_floor);
    plan_state[ch] = u.state;
    pending_cmds.push_back(cmd);
    items_queued++;
    if (!(op == OP_TICK && !u.res.changed)) useful_items++;
  endtask

  function automatic logic [7:0] pick_speed();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd255;
    if (r < 50) return 8'($urandom_range(40, 1));
    return 8'($urandom_range(255));
  endfunction

  // Targets are mostly near the current position, so that moves finish in a
  // few dozen ticks; the rest cover the already-held target, travel of one
  // to three (a zero quarter), both ends of the range and anywhere at all.
  function automatic logic [11:0] pick_target(logic [11:0] from);
    int r;
    int t;
    r = $urandom_range(99);
    if (r < 10) return from;
    if (r < 15) return 12'd0;
    if (r < 20) return 12'hFFF;
    if (r < 35) return 12'($urandom_range(4095));
    if (r < 45) begin
      t = int'(from) + (($urandom_range(1) != 0) ? 1 : -1) * int'($urandom_range(3, 1));
    end else begin
      t = int'(from) + int'($urandom_range(600)) - 300;
    end
    if (t < 0) t = 0;
    if (t > 4095) t = 4095;
    return 12'(t);
  endfunction

  // Waits until every queued item has been taken and every result has come
  // back, then lets the block settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (items_accepted != items_queued || expected_reports.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_min_step(input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    min_step <= value;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random phase. Most of it is move sequences ticked until arrival (or
  // a cap), with commands on the other channel mixed in and now and then a
  // detach and reattach in the middle of the travel; the rest is noise.
  task automatic run_random(input int n_items, input int snd_pct, input int rcv_pct);
    int   base;
    int   ticks_left;
    int   r;
    logic ch;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    plan_state = servo_state;
    plan_floor = step_floor;
    base = useful_items;
    while (useful_items - base < n_items) begin
      ch = 1'($urandom_range(1));
      if ($urandom_range(99) < 70) begin
        queue_cmd(OP_MOVE, ch, pick_speed(), pick_target(plan_state[ch].pos));
        ticks_left = $urandom_range(60, 4);
        while (ticks_left > 0 && plan_state[ch].att &&
               plan_state[ch].pos != plan_state[ch].goal) begin
          r = $urandom_range(99);
          if (r < 20) begin
            queue_cmd(2'($urandom_range(3)), !ch, 8'($urandom_range(255)),
                      pick_target(plan_state[!ch].pos));
          end else if (r < 24) begin
            queue_cmd(OP_DETACH, ch, 8'($urandom_range(255)), 12'($urandom_range(4095)));
            queue_cmd(OP_TICK, ch, 8'($urandom_range(255)), 12'($urandom_range(4095)));
            queue_cmd(OP_ATTACH, ch, 8'($urandom_range(255)), 12'($urandom_range(4095)));
          end
          queue_cmd(OP_TICK, ch, 8'($urandom_range(255)), 12'($urandom_range(4095)));
          ticks_left--;
        end
      end else begin
        queue_cmd(2'($urandom_range(3)), ch, 8'($urandom_range(255)),
                  12'($urandom_range(4095)));
      end
    end
    wait_drained();
  endtask

  // Input driver: holds an item until the edge that takes it, then offers
  // the next one from the queue unless it decides to idle this cycle. The
  // item on the port is still waiting while more have been sent than taken.
  always @(negedge clk) begin
    send_next = in_valid && (items_sent != items_accepted);
    if (!send_next && !rst && pending_cmds.size() != 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      next_cmd = pending_cmds.pop_front();
      opcode <= next_cmd.op;
      channel <= next_cmd.chan;
      speed <= next_cmd.speed;
      target <= next_cmd.target;
      items_sent++;
      send_next = 1'b1;
    end
    in_valid <= send_next;
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: checks results against the oldest prediction, predicts each
  // accepted item, tracks register writes and watches for a hang. The result
  // is checked before the new prediction is queued, so an item taken at the
  // same edge can never be matched against its own result.
  always @(posedge clk) begin
    servo_cmd_t    cmd;
    servo_update_t u;
    servo_report_t want;
    if (rst) begin
      for (int c = 0; c < 2; c++) servo_state[c] = '0;
      step_floor = MIN_STEP_RESET;
      idle_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual ch=%0d pos=%0d",
                   $time, out_channel, position);
        end else begin
          want = expected_reports.pop_front();
          if (out_channel !== want.chan || position !== want.pos ||
              position_changed !== want.changed || arrived !== want.arrived ||
              is_attached !== want.att || is_moving !== want.mov) begin
            mismatches++;
            $display({"%0t: result mismatch, expected ch=%0d pos=%0d chg=%b arr=%b ",
                      "att=%b mov=%b, actual ch=%0d pos=%0d chg=%b arr=%b att=%b mov=%b"},
                     $time, want.chan, want.pos, want.changed, want.arrived, want.att,
                     want.mov, out_channel, position, position_changed, arrived,
                     is_attached, is_moving);
          end
        end
      end
      if (cfg_valid && cfg_ready) step_floor = min_step;
      if (in_valid && in_ready) begin
        cmd.op = opcode;
        cmd.chan = channel;
        cmd.speed = speed;
        cmd.target = target;
        u = ramp_step(servo_state[channel], cmd, step_floor);
        servo_state[channel] = u.state;
        expected_reports.push_back(u.res);
        items_accepted++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset floor of 20: a tick on a detached channel,
    // a move to the position already held, full-range travel with both
    // payload extremes, detach and reattach in mid travel, a zero-speed move,
    // a travel too short to have a quarter, and a tick on a finished channel.
    plan_state = servo_state;
    plan_floor = step_floor;
    queue_cmd(OP_TICK, 1'b0, 8'd0, 12'd0);
    queue_cmd(OP_MOVE, 1'b0, 8'd255, 12'd0);
    queue_cmd(OP_MOVE, 1'b0, 8'd255, 12'hFFF);
    repeat (4) queue_cmd(OP_TICK, 1'b0, 8'hFF, 12'hFFF);
    queue_cmd(OP_DETACH, 1'b0, 8'd0, 12'd0);
    queue_cmd(OP_TICK, 1'b0, 8'd0, 12'd0);
    queue_cmd(OP_ATTACH, 1'b0, 8'd0, 12'd0);
    queue_cmd(OP_TICK, 1'b0, 8'd0, 12'd0);
    queue_cmd(OP_MOVE, 1'b0, 8'd0, 12'd0);
    repeat (2) queue_cmd(OP_TICK, 1'b0, 8'd0, 12'd0);
    queue_cmd(OP_MOVE, 1'b1, 8'd255, 12'd3);
    queue_cmd(OP_TICK, 1'b1, 8'd0, 12'd0);
    queue_cmd(OP_TICK, 1'b1, 8'd0, 12'd0);
    queue_cmd(OP_MOVE, 1'b1, 8'd7, 12'd3);
    queue_cmd(OP_MOVE, 1'b1, 8'd200, 12'hFFF);
    repeat (2) queue_cmd(OP_TICK, 1'b1, 8'd0, 12'd0);
    queue_cmd(OP_DETACH, 1'b1, 8'd0, 12'd0);
    queue_cmd(OP_TICK, 1'b1, 8'd0, 12'd0);
    wait_drained();

    // Random phases over several floors, the extremes and a zero among
    // them. Each phase boundary also makes the sender pause until every
    // outstanding result is back.
    write_min_step(8'd1);
    run_random(70, 9, 79);
    write_min_step(8'd255);
    run_random(70, 9, 79);
    write_min_step(8'd0);
    run_random(60, 79, 9);
    write_min_step(8'($urandom_range(254, 2)));
    run_random(70, 79, 9);
    write_min_step(MIN_STEP_RESET);
    run_random(70, 0, 0);
    write_min_step(8'($urandom_range(254, 2)));
    run_random(60, 0, 0);

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
